@@ rtl/sstf_pkg.sv @@
// Shared constants, payload structs and control types of the SSTF disk scheduler.
`default_nettype none

package sstf_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int CYLINDER_BITS = 16;

   localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
   localparam int SUM_BITS = 22;

   typedef struct packed {
      logic [15:0] cylinder;
      logic        last_request;
   } req_type;

   typedef struct packed {
      logic [15:0]         served_cylinder;
      logic [15:0]         seek_distance;
      logic [SUM_BITS-1:0] total_movement;
      logic                overflow;
      logic                last_served;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // compare request into the nearest-request search unit
   typedef struct packed {
      logic                clear;
      logic                cmp_valid;
      logic                cmp_served;
      logic [IDX_BITS-1:0] cmp_idx;
   } sel_ctl_type;

   // current winner of the search
   typedef struct packed {
      logic                     found;
      logic [IDX_BITS-1:0]      best_idx;
      logic [CYLINDER_BITS-1:0] best_cyl;
      logic [CYLINDER_BITS-1:0] best_dist;
   } sel_res_type;

endpackage

`default_nettype wire

@@ rtl/sstf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sstf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/sstf_sel.sv @@
// Nearest-request search unit: one compare per beat of RAM read data.
`default_nettype none

module sstf_sel (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [sstf_pkg::CYLINDER_BITS-1:0]   head,
   input  wire logic [sstf_pkg::CYLINDER_BITS-1:0]   rd_data,
   input  wire sstf_pkg::sel_ctl_type                ctl,
   output sstf_pkg::sel_res_type                     res
);

   import sstf_pkg::*;

   logic                     found_ff, found_in;
   logic [IDX_BITS-1:0]      best_idx_ff, best_idx_in;
   logic [CYLINDER_BITS-1:0] best_cyl_ff, best_cyl_in;
   logic [CYLINDER_BITS-1:0] best_dist_ff, best_dist_in;
   logic [CYLINDER_BITS-1:0] seek_dist;
   logic                     take;

   assign seek_dist = (head >= rd_data) ? (head - rd_data) : (rd_data - head);
   // strict less-than keeps the earliest-loaded entry on a tie
   assign take = ctl.cmp_valid && !ctl.cmp_served &&
                 (!found_ff || (seek_dist < best_dist_ff));

   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_cyl_in  = best_cyl_ff;
      best_dist_in = best_dist_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in     = 1'b1;
         best_idx_in  = ctl.cmp_idx;
         best_cyl_in  = rd_data;
         best_dist_in = seek_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff  <= best_idx_in;
      best_cyl_ff  <= best_cyl_in;
      best_dist_ff <= best_dist_in;
   end

   assign res.found     = found_ff;
   assign res.best_idx  = best_idx_ff;
   assign res.best_cyl  = best_cyl_ff;
   assign res.best_dist = best_dist_ff;

endmodule

`default_nettype wire

@@ rtl/sstf_disk_scheduler.sv @@
// Top level of the shortest-seek-time-first disk scheduler.
// Requests arrive one beat each on the req_ channel and are written into a
// 32-entry request RAM, one beat per cycle, req_stall low while loading. The
// beat marked last_request starts scheduling from the cylinder held in the
// start_head register (written through csr_write_en / csr_write_data; the
// user must write it only while idle, the block does not enforce this). For a
// batch of n requests each result needs n reads of the single RAM read port,
// each compared against the current head in the search unit in the cycle
// after its read, then a drain and an emit, with req_stall high throughout.
// Requests beyond capacity are dropped and reported on every result of that
// batch through overflow. The result sits in an output register, so the next
// batch can start loading while the last result still waits on rsp_stall.
`default_nettype none

module sstf_disk_scheduler (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sstf_pkg::req_type req_payload,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sstf_pkg::rsp_type      rsp_payload,
   // start_head register
   input  wire logic              csr_write_en,
   input  wire logic [15:0]       csr_write_data
);

   import sstf_pkg::*;

   state_type                state_ff, state_in;

   logic [15:0]              start_head_ff, start_head_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;      // loaded requests
   logic [CNT_BITS-1:0]      issue_ff, issue_in;      // next RAM address of the scan
   logic [CNT_BITS-1:0]      step_ff, step_in;        // results emitted this batch
   logic [MAX_REQUESTS-1:0]  served_ff, served_in;
   logic                     dropped_ff, dropped_in;
   logic [CYLINDER_BITS-1:0] head_ff, head_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]      rd_idx_ff, rd_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     req_accept;
   logic                     batch_start;
   logic                     load_en;
   logic                     issue_en;
   logic                     scan_done;
   logic                     emit_fire;
   logic                     emit_last;
   logic [CYLINDER_BITS-1:0] req_cyl;
   logic [CYLINDER_BITS-1:0] rd_data;
   logic [SUM_BITS-1:0]      sum_next;
   sel_ctl_type              sel_ctl;
   sel_res_type              sel_res;

   // ---------------------------------------------------------------
   // request RAM and search unit
   // ---------------------------------------------------------------
   assign req_cyl = CYLINDER_BITS'(req_payload.cylinder);

   sstf_ram #(
      .WIDTH (CYLINDER_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (req_cyl),
      .rd_en   (issue_en),
      .rd_addr (issue_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign sel_ctl.clear      = batch_start || (emit_fire && !emit_last);
   assign sel_ctl.cmp_valid  = rd_valid_ff;
   assign sel_ctl.cmp_served = served_ff[rd_idx_ff];
   assign sel_ctl.cmp_idx    = rd_idx_ff;

   sstf_sel u_sel (
      .clock   (clock),
      .reset   (reset),
      .head    (head_ff),
      .rd_data (rd_data),
      .ctl     (sel_ctl),
      .res     (sel_res)
   );

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   // scan finished once every address is issued and the last compare is in
   assign scan_done = (issue_ff == count_ff) && !rd_valid_ff;
   assign emit_last = (step_ff == CNT_BITS'(count_ff - 1'b1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_payload.last_request) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = emit_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      issue_en  = 1'b0;
      emit_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SCAN: issue_en = (issue_ff != count_ff);
         ST_EMIT: emit_fire = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   assign req_accept  = req_valid && !req_stall;
   assign batch_start = req_accept && req_payload.last_request;
   assign load_en     = req_accept && (count_ff != CNT_BITS'(MAX_REQUESTS));
   assign sum_next    = sum_ff + SUM_BITS'(sel_res.best_dist);

   // ---------------------------------------------------------------
   // datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      start_head_in = csr_write_en ? csr_write_data : start_head_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      step_in       = step_ff;
      served_in     = served_ff;
      dropped_in    = dropped_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      rd_valid_in   = issue_en;
      rd_idx_in     = issue_ff[IDX_BITS-1:0];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (issue_en) begin
         issue_in = issue_ff + 1'b1;
      end

      if (load_en) begin
         served_in[count_ff[IDX_BITS-1:0]] = 1'b0;
         count_in = count_ff + 1'b1;
      end else if (req_accept) begin
         dropped_in = 1'b1;
      end

      if (batch_start) begin
         head_in  = CYLINDER_BITS'(start_head_ff);
         sum_in   = '0;
         step_in  = '0;
         issue_in = '0;
      end

      if (emit_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_in.served_cylinder      = 16'(sel_res.best_cyl);
         rsp_in.seek_distance        = 16'(sel_res.best_dist);
         rsp_in.total_movement       = sum_next;
         rsp_in.overflow             = dropped_ff;
         rsp_in.last_served          = emit_last;
         head_in                     = sel_res.best_cyl;
         issue_in                    = '0;
         if (emit_last) begin
            // batch done: the head stays where it ended
            served_in  = '0;
            count_in   = '0;
            sum_in     = '0;
            dropped_in = 1'b0;
            step_in    = '0;
         end else begin
            served_in[sel_res.best_idx] = 1'b1;
            sum_in  = sum_next;
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_head_ff <= '0;
         count_ff      <= '0;
         issue_ff      <= '0;
         step_ff       <= '0;
         served_ff     <= '0;
         dropped_ff    <= 1'b0;
         head_ff       <= '0;
         sum_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_head_ff <= start_head_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         step_ff       <= step_in;
         served_ff     <= served_in;
         dropped_ff    <= dropped_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_REQUESTS))
      else $error("loaded count beyond capacity");

   a_emit_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> sel_res.found)
      else $error("emit without a selected request");

   a_pick_unserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !served_ff[sel_res.best_idx])
      else $error("selected request already served");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      load_en |-> (state_ff == ST_IDLE))
      else $error("request RAM written while scheduling");

   a_batch_end_clear: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> (count_ff == '0) && (state_ff == ST_IDLE))
      else $error("batch state not cleared after last result");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the SSTF disk scheduler: directed rows, then random batches.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sstf_pkg::*;

   // Run length and pacing knobs.
   localparam int ITEM_TARGET  = 330;     // directed rows plus about 320 random beats
   localparam int IDLE_SETTLE  = 8;       // idle cycles before a start_head write
   localparam int DRAIN_CYCLES = 64;      // quiet time after the last result
   localparam int CYCLE_LIMIT  = 600000;  // watchdog, far above the slowest legal run

   // Kinds of rows in the directed stimulus table.
   typedef enum logic {
      ROW_CSR,
      ROW_REQ
   } row_kind_e;

   // How the cylinders of one random batch are drawn.
   typedef enum logic [1:0] {
      MIX_UNIFORM,   // anywhere on the disk
      MIX_CLUSTER,   // narrow window: duplicates and equal seeks
      MIX_EXTREME,   // disk edges and the start cylinder
      MIX_MIRROR     // pairs either side of the start cylinder: ties
   } mix_e;

   typedef struct {
      row_kind_e   kind;
      logic [15:0] value;   // cylinder, or start_head for a CSR row
      logic        last;
      bit          typed;   // expected result written in the row itself
      rsp_type     want;
   } steer_row_t;

   // DUT interface
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;

   // Predictor state: a shadow of the request store and the start_head register.
   logic [15:0] shadow_cyl [MAX_REQUESTS];
   int          shadow_count = 0;
   logic        shadow_dropped = 1'b0;
   logic [15:0] start_head_q = '0;

   rsp_type     batch_plan[$];         // service order of the batch just closed
   rsp_type     expected_service[$];   // results still owed by the DUT
   steer_row_t  steer_rows[$];

   // Bookkeeping
   int          error_count = 0;
   int          items_sent = 0;
   int          result_count = 0;
   int          batch_count = 0;
   int          overflow_batches = 0;
   int          phase_count = 0;
   int          cycle_count = 0;
   bit          quiet_mode = 1'b0;     // no gaps and no new stalls while set
   int          stall_hold = 0;
   rsp_type     got_want;

   always #1 clock = ~clock;

   sstf_disk_scheduler u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 2);
      if (roll < 92) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("MISMATCH @%0t: %s: got %0d, want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Shortest-seek-first prediction. Loads one beat into the shadow store; on
   // the beat marked last, fills batch_plan with the full service order and
   // clears the per-batch state. Head always restarts at start_head.
   function automatic void sstf_predict(input req_type beat);
      bit          served [MAX_REQUESTS];
      logic [15:0] head;
      logic [15:0] seek;
      logic [15:0] best;
      logic [21:0] sum;
      int          pick;
      rsp_type     step;
      batch_plan.delete();
      if (shadow_count < MAX_REQUESTS) begin
         shadow_cyl[shadow_count] = beat.cylinder;
         shadow_count++;
      end else begin
         shadow_dropped = 1'b1;   // store full: beat is lost, flag sticks for the batch
      end
      if (!beat.last_request) return;
      head = start_head_q;
      sum  = '0;
      best = '0;
      for (int i = 0; i < MAX_REQUESTS; i++) served[i] = 1'b0;
      for (int s = 0; s < shadow_count; s++) begin
         pick = -1;
         for (int i = 0; i < shadow_count; i++) begin
            if (!served[i]) begin
               seek = (head >= shadow_cyl[i]) ? head - shadow_cyl[i] : shadow_cyl[i] - head;
               // strict compare: earliest loaded entry wins a tie
               if (pick < 0 || seek < best) begin
                  best = seek;
                  pick = i;
               end
            end
         end
         served[pick] = 1'b1;
         sum  = sum + 22'(best);
         head = shadow_cyl[pick];
         step.served_cylinder = head;
         step.seek_distance   = best;
         step.total_movement  = sum;
         step.overflow        = shadow_dropped;
         step.last_served     = (s == shadow_count - 1);
         batch_plan.push_back(step);
      end
      shadow_count   = 0;
      shadow_dropped = 1'b0;
   endfunction

   // Present one request beat and hold it until the DUT takes it. Called and
   // returns at a falling edge; valid stays high if the next beat follows at once.
   task automatic drive_request(input logic [15:0] cyl, input logic last,
                                input bit typed, input rsp_type want);
      int gap;
      gap = (quiet_mode || $urandom_range(0, 1) == 0) ? 0 : gap_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = '{cylinder: cyl, last_request: last};
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // beat accepted at this edge
      sstf_predict(req_payload);
      if (typed) begin
         expected_service.push_back(want);
      end else begin
         foreach (batch_plan[k]) expected_service.push_back(batch_plan[k]);
      end
      items_sent++;
      if (last) batch_count++;
      @(negedge clock);
   endtask

   // Write start_head only with the block idle: every owed result delivered,
   // then a few spare cycles.
   task automatic load_start_head(input logic [15:0] value);
      req_valid = 1'b0;
      while (expected_service.size() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      start_head_q = value;
      phase_count++;
   endtask

   // One random batch; forced_count of zero picks the size at random.
   task automatic run_random_batch(input int forced_count);
      int          count;
      int          roll;
      int unsigned offset;
      mix_e        mix;
      logic [15:0] base;
      logic [15:0] cyl;
      roll = $urandom_range(0, 99);
      if (forced_count > 0)  count = forced_count;
      else if (roll < 60)    count = $urandom_range(1, 6);
      else if (roll < 85)    count = $urandom_range(7, 16);
      else if (roll < 95)    count = $urandom_range(17, MAX_REQUESTS);
      else                   count = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
      mix  = mix_e'($urandom_range(0, 3));
      base = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         case (mix)
            MIX_UNIFORM: cyl = 16'($urandom);
            MIX_CLUSTER: cyl = base + 16'($urandom_range(0, 15));
            MIX_EXTREME: begin
               roll = $urandom_range(0, 3);
               cyl  = (roll == 0) ? 16'h0000 :
                      (roll == 1) ? 16'hFFFF :
                      (roll == 2) ? start_head_q : 16'($urandom);
            end
            default: begin
               offset = $urandom_range(0, 8);
               cyl = ($urandom_range(0, 1) == 0) ? start_head_q + 16'(offset)
                                                 : start_head_q - 16'(offset);
            end
         endcase
         drive_request(cyl, i == count - 1, 1'b0, '0);
      end
      if (count > MAX_REQUESTS) overflow_batches++;
   endtask

   // Directed table builders.
   task automatic row_csr(input logic [15:0] value);
      steer_rows.push_back('{kind: ROW_CSR, value: value, last: 1'b0, typed: 1'b0, want: '0});
   endtask

   task automatic row_req(input logic [15:0] cyl, input logic last);
      steer_rows.push_back('{kind: ROW_REQ, value: cyl, last: last, typed: 1'b0, want: '0});
   endtask

   // Single-request batch whose one result can be written down directly.
   task automatic row_single(input logic [15:0] cyl, input logic [15:0] seek);
      rsp_type want;
      want.served_cylinder = cyl;
      want.seek_distance   = seek;
      want.total_movement  = 22'(seek);
      want.overflow        = 1'b0;
      want.last_served     = 1'b1;
      steer_rows.push_back('{kind: ROW_REQ, value: cyl, last: 1'b1, typed: 1'b1, want: want});
   endtask

   // Random stall on the result side: runs of stall and of no stall.
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (quiet_mode) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall  = ($urandom_range(0, 2) == 0);
         stall_hold = gap_length();
      end
   end

   // Result checker: every accepted beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_service.size() == 0) begin
            flag_mismatch("result beat with nothing owed", rsp_payload.served_cylinder, 0);
         end else begin
            got_want = expected_service.pop_front();
            result_count++;
            if (rsp_payload.served_cylinder !== got_want.served_cylinder)
               flag_mismatch("served_cylinder", rsp_payload.served_cylinder,
                             got_want.served_cylinder);
            if (rsp_payload.seek_distance !== got_want.seek_distance)
               flag_mismatch("seek_distance", rsp_payload.seek_distance,
                             got_want.seek_distance);
            if (rsp_payload.total_movement !== got_want.total_movement)
               flag_mismatch("total_movement", rsp_payload.total_movement,
                             got_want.total_movement);
            if (rsp_payload.overflow !== got_want.overflow)
               flag_mismatch("overflow", rsp_payload.overflow, got_want.overflow);
            if (rsp_payload.last_served !== got_want.last_served)
               flag_mismatch("last_served", rsp_payload.last_served, got_want.last_served);
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int          batches;
      logic [15:0] head_pick;

      // Directed part. Head starts at cylinder 0 out of reset.
      row_single(16'h0000, 16'h0000);       // zero seek, zero total
      row_single(16'hFFFF, 16'hFFFF);       // full-stroke seek from the reset head
      row_csr(16'd1000);
      row_req(16'd990, 1'b0);               // equal seeks either side of the head
      row_req(16'd1010, 1'b0);
      row_req(16'd1000, 1'b1);              // request under the head goes first
      row_req(16'd1010, 1'b0);              // tie at the very first pick
      row_req(16'd990, 1'b1);
      row_csr(16'hFFFF);
      row_single(16'h0000, 16'hFFFF);       // full stroke downward
      row_single(16'hFFFF, 16'h0000);
      row_req(16'hFFFF, 1'b0);              // duplicates at the top edge
      row_req(16'hFFFF, 1'b1);
      row_req(16'h0000, 1'b0);              // alternate edges
      row_req(16'h8000, 1'b0);
      row_req(16'h7FFF, 1'b1);
      row_csr(16'h5555);
      row_req(16'hAAAA, 1'b0);
      row_req(16'h5554, 1'b0);
      row_req(16'h5556, 1'b1);

      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (steer_rows[r]) begin
         if (steer_rows[r].kind == ROW_CSR)
            load_start_head(steer_rows[r].value);
         else
            drive_request(steer_rows[r].value, steer_rows[r].last,
                          steer_rows[r].typed, steer_rows[r].want);
      end

      // Random part: phases of one start_head each, a few batches per phase.
      // The first random phase forces an overrun batch, the third an exactly full batch.
      while (items_sent < ITEM_TARGET) begin
         if (phase_count % 5 == 0)      head_pick = 16'hFFFF;
         else if (phase_count % 5 == 1) head_pick = 16'h0000;
         else                           head_pick = 16'($urandom);
         load_start_head(head_pick);
         quiet_mode = (phase_count % 4 == 3);   // some stretches run flat out
         batches = $urandom_range(1, 4);
         for (int b = 0; b < batches; b++) begin
            if (b == 0 && overflow_batches == 0)   run_random_batch(MAX_REQUESTS + 2);
            else if (b == 0 && phase_count == 6)   run_random_batch(MAX_REQUESTS);
            else                                   run_random_batch(0);
         end
      end
      req_valid  = 1'b0;
      quiet_mode = 1'b0;

      // Let the last batch drain, then watch for stray beats.
      while (expected_service.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_service.size() != 0)
         flag_mismatch("results never delivered", 0, expected_service.size());

      $display("Sent %0d request beats in %0d batches over %0d start_head settings",
               items_sent, batch_count, phase_count);
      $display("Checked %0d result beats; %0d batches overran the request store",
               result_count, overflow_batches);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
